/* src/scan_priority_queue_fifo_ties_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scan priority queue
// Shared macros that the checker uses to write its concurrent properties.
// ----------------------------------------------------------------------------
`ifndef SCAN_PRIORITY_QUEUE_FIFO_TIES_DEFINES_SVH
`define SCAN_PRIORITY_QUEUE_FIFO_TIES_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq property violated");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq property violated");

`endif

/* src/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and codes shared by the scan priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Queue geometry.
    localparam int DEPTH         = 16;
    localparam int PAYLOAD_WIDTH = 32;

    // Fixed transaction field widths.
    localparam int PRIO_W   = 16;
    localparam int PAY_IN_W = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Derived sizes.
    localparam int STORE_PW = (PAYLOAD_WIDTH < PAY_IN_W) ? PAYLOAD_WIDTH : PAY_IN_W;
    localparam int ENTRY_W  = PRIO_W + STORE_PW;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Operation codes.
    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic accept;
        logic enq;
        logic reject;
        logic scan_start;
        logic scan_step;
        logic shift_step;
        logic load_out;
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic op_deq;
        logic empty;
        logic full;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } spq_stat_t;

endpackage

`default_nettype wire

/* src/spq_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_in_if
// Request channel: one enqueue or dequeue transaction per handshake.
// ----------------------------------------------------------------------------
interface spq_in_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [PRIO_W-1:0] priority_req;
    logic [PAY_IN_W-1:0]      payload;

    modport source (output valid, output operation, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input operation, input priority_req, input payload,
                    output ready);
endinterface

`default_nettype wire

/* src/spq_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_out_if
// Response channel: one result transaction for every request.
// ----------------------------------------------------------------------------
interface spq_out_if;
    import spq_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output data_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input data_out, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

/* src/spq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/spq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: entry store, fill count, scan and compaction pointers, result register.
// ----------------------------------------------------------------------------
module spq_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire spq_pkg::spq_cmd_t               cmd,
    output spq_pkg::spq_stat_t                   stat,
    input  wire logic                            item_op,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] item_prio,
    input  wire logic [spq_pkg::PAY_IN_W-1:0]    item_pay,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [spq_pkg::DATA_W-1:0]           out_data,
    output logic [spq_pkg::STATUS_W-1:0]         out_status,
    output logic [spq_pkg::OCC_W-1:0]            out_occ
);
    import spq_pkg::*;

    // Control registers.
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // Item and scan registers.
    logic                     op_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    logic [STORE_PW-1:0]      pay_reg;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic signed [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [STORE_PW-1:0]      res_pay_reg, res_pay_next;
    status_t                  res_status_reg, res_status_next;

    // Output registers.
    logic [DATA_W-1:0]   out_data_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OCC_W-1:0]    out_occ_reg;

    // Memory port signals.
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [ENTRY_W-1:0]       mem_wdata;
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_raddr;
    logic [ENTRY_W-1:0]       mem_rdata;
    logic signed [PRIO_W-1:0] rd_prio;
    logic [STORE_PW-1:0]      rd_pay;
    logic                     better;
    logic [CNT_W-1:0]         count_last;
    logic [CNT_W-1:0]         shift_dst;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Fields of the entry that was read in the previous cycle.
    assign rd_prio    = mem_rdata[ENTRY_W-1 -: PRIO_W];
    assign rd_pay     = mem_rdata[STORE_PW-1:0];
    assign count_last = count_reg - CNT_W'(1);
    assign shift_dst  = rd_idx_reg - CNT_W'(1);

    // The first slot always starts the search; later ones win only when strictly higher.
    assign better = (rd_idx_reg == '0) || (rd_prio > best_prio_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.op_deq     = (op_reg == OP_DEQUEUE);
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CNT_W'(DEPTH));
        stat.scan_last  = (rd_idx_reg == count_last);
        stat.shift_done = (rd_idx_reg >= count_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Next-state logic for the store, pointers and result.
    always_comb
    begin
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        best_prio_next  = best_prio_reg;
        best_idx_next   = best_idx_reg;
        res_pay_next    = res_pay_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = {prio_reg, pay_reg};
        mem_re          = 1'b0;
        mem_raddr       = '0;

        if (cmd.enq)
        begin
            mem_we          = 1'b1;
            count_next      = count_reg + CNT_W'(1);
            res_pay_next    = '0;
            res_status_next = ST_OK;
        end

        if (cmd.reject)
        begin
            res_pay_next    = '0;
            res_status_next = (op_reg == OP_DEQUEUE) ? ST_EMPTY : ST_FULL;
        end

        if (cmd.scan_start)
        begin
            rd_idx_next     = '0;
            mem_re          = 1'b1;
            mem_raddr       = '0;
            res_status_next = ST_OK;
        end

        if (cmd.scan_step)
        begin
            if (better)
            begin
                best_prio_next = rd_prio;
                best_idx_next  = rd_idx_reg[IDX_W-1:0];
                res_pay_next   = rd_pay;
            end
            // After the last slot, compaction starts just above the winner.
            if (stat.scan_last)
            begin
                rd_idx_next = CNT_W'(best_idx_next) + CNT_W'(1);
            end
            else
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            mem_re    = (rd_idx_next < count_reg);
            mem_raddr = rd_idx_next[IDX_W-1:0];
        end

        if (cmd.shift_step)
        begin
            if (stat.shift_done)
            begin
                count_next = count_last;
            end
            else
            begin
                // Move the entry just read down one slot and fetch the next one.
                mem_we      = 1'b1;
                mem_waddr   = shift_dst[IDX_W-1:0];
                mem_wdata   = mem_rdata;
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                mem_re      = (rd_idx_next < count_reg);
                mem_raddr   = rd_idx_next[IDX_W-1:0];
            end
        end
    end

    // Output valid tracking.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= item_op;
            prio_reg <= item_prio;
            pay_reg  <= item_pay[STORE_PW-1:0];
        end
        rd_idx_reg     <= rd_idx_next;
        best_prio_reg  <= best_prio_next;
        best_idx_reg   <= best_idx_next;
        res_pay_reg    <= res_pay_next;
        res_status_reg <= res_status_next;
        if (cmd.load_out)
        begin
            out_data_reg   <= DATA_W'(res_pay_reg);
            out_status_reg <= res_status_reg;
            out_occ_reg    <= OCC_W'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_occ    = out_occ_reg;

endmodule

`default_nettype wire

/* src/spq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: sequences accept, decision, scan, compaction and result hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t       cmd
);
    import spq_pkg::*;

    typedef enum logic [4:0]
    {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Transition and command logic.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.op_deq)
                begin
                    if (stat.empty)
                    begin
                        cmd.reject = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else if (stat.full)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.enq    = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/scan_priority_queue_fifo_ties.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scan_priority_queue_fifo_ties
// Bounded priority queue with linear scan; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// Each request transaction is an enqueue or a dequeue and yields exactly one response
// transaction carrying the removed payload, a status and the occupancy after the
// request. Entries sit in one RAM in arrival order; a dequeue reads them one per cycle
// to find the highest priority (earliest wins ties), then shifts the later entries
// down one slot, one per cycle, through the same single read and write port. An
// enqueue, a full enqueue or an empty dequeue goes straight from the decision to the
// response; a dequeue scans all stored entries and then shifts those above the winner.
// One request is in work at a time, and the next is accepted while the previous
// response still waits in the output register.
// ----------------------------------------------------------------------------
module scan_priority_queue_fifo_ties (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_in_if.sink     req,
    spq_out_if.source  rsp
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;
    logic      in_ready;

    // Sequencing.
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store and arithmetic.
    spq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .item_op    (req.operation),
        .item_prio  (req.priority_req),
        .item_pay   (req.payload),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_data   (rsp.data_out),
        .out_status (rsp.status),
        .out_occ    (rsp.occupancy)
    );

    assign req.ready = in_ready;

endmodule

`default_nettype wire

/* src/spq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level properties of the scan priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_priority_queue_fifo_ties_defines.svh"

module spq_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [spq_pkg::DATA_W-1:0]    rsp_data,
    input  wire logic [spq_pkg::STATUS_W-1:0]  rsp_status,
    input  wire logic [spq_pkg::OCC_W-1:0]     rsp_occ
);
    import spq_pkg::*;

    // A stalled response transaction stays offered with the same contents.
    `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_status) && $stable(rsp_occ))

    // An empty dequeue reports an empty queue and no data.
    `SPQ_ASSERT_NOW(a_empty_result, rsp_valid && (rsp_status == ST_EMPTY), (rsp_occ == '0) && (rsp_data == '0))

    // A dropped enqueue reports a full queue and no data.
    `SPQ_ASSERT_NOW(a_full_result, rsp_valid && (rsp_status == ST_FULL), (rsp_occ == OCC_W'(DEPTH)) && (rsp_data == '0))

endmodule

bind scan_priority_queue_fifo_ties spq_checker u_spq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_data   (rsp.data_out),
    .rsp_status (rsp.status),
    .rsp_occ    (rsp.occupancy)
);

`default_nettype wire
